>>> src/scsa_pkg.sv
// Shared types, codes and constants of the size class slot allocator.
// No dependencies; the top level, controller, datapath and testbench import this package.
package scsa_pkg;

    localparam int unsigned SCSA_POOL_BYTES = 1048576;

    localparam int CLASS_CNT = 4;
    localparam int CLASS_W   = 2;
    localparam int ADDR_W    = 20;
    localparam int SIZE_W    = 16;
    localparam int COPY_W    = 11;
    localparam int MAX_CAP   = 1024;

    typedef enum logic [1:0] {
        OP_ALLOC,
        OP_FREE,
        OP_RESIZE,
        OP_NONE
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK,
        ST_TOO_LARGE,
        ST_EXHAUSTED,
        ST_OUTSIDE
    } t_status;

    // How the result fields are composed when a result is loaded.
    typedef enum logic [2:0] {
        OUT_ZERO,
        OUT_FREE,
        OUT_KEEP,
        OUT_ALLOC,
        OUT_MOVE
    } t_out_kind;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_POP
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [SIZE_W-1:0] request_size;
        logic [ADDR_W-1:0] slot_address;
    } t_req;

    typedef struct packed {
        logic [ADDR_W-1:0]  result_address;
        logic [1:0]         status;
        logic [CLASS_W-1:0] size_class;
        logic [COPY_W-1:0]  copy_length;
        logic               moved;
    } t_rsp;

    typedef struct packed {
        logic      clear_step;
        logic      load_in;
        logic      push;
        logic      pop_read;
        logic      pop_commit;
        logic      load_out;
        t_out_kind out_kind;
        t_status   out_status;
    } t_ctrl_cmd;

    typedef struct packed {
        logic    clear_done;
        logic    out_free;
        t_opcode opcode;
        logic    too_large;
        logic    head_ok;
        logic    addr_ok;
        logic    fits;
    } t_dp_status;

    function automatic logic [COPY_W-1:0] cap_bytes(input logic [CLASS_W-1:0] c);
        logic [COPY_W-1:0] v;
        unique case (c)
            2'd0:    v = COPY_W'(64);
            2'd1:    v = COPY_W'(256);
            2'd2:    v = COPY_W'(512);
            default: v = COPY_W'(1024);
        endcase
        return v;
    endfunction

    function automatic logic [3:0] cap_shift(input logic [CLASS_W-1:0] c);
        logic [3:0] v;
        unique case (c)
            2'd0:    v = 4'd6;
            2'd1:    v = 4'd8;
            2'd2:    v = 4'd9;
            default: v = 4'd10;
        endcase
        return v;
    endfunction

endpackage

>>> src/scsa_stream_if.sv
// Valid/ready stream interface used for the request and response channels.
// The payload type is a parameter; no package dependency.
interface scsa_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> src/size_class_slot_allocator_unit.sv
// Size class slot allocator, top level. Uses scsa_pkg, scsa_stream_if,
// scsa_ctrl, scsa_datapath and scsa_ram. Free, fitting resize, errors and the
// unused opcode are answered from decode; allocate and moving resize also pass
// through the pop state (registered link RAM read). A new request is taken only
// once the controller is back in idle, after decode or pop of the last one.
// Reset: a clearing pass over every slot builds the free lists first.
module size_class_slot_allocator_unit
    import scsa_pkg::*;
#(
    parameter int unsigned POOL_BYTES = SCSA_POOL_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    scsa_stream_if.sink   i_req,
    scsa_stream_if.source o_rsp
);
    // The pool is cut into four equal regions, one per size class of 64, 256,
    // 512 and 1024 byte slots. Each class keeps a LIFO free list: a head
    // register per class and one link word per slot in a single RAM. A link
    // word carries the next free slot and a bit that says whether it exists.

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;
    logic       w_accept;
    t_req       w_req;
    t_rsp       w_rsp;
    logic       w_out_valid;

    // A request transfer happens while the controller waits in its idle state.
    // The result register is separate, so a request can be taken while the
    // previous result still waits for its transfer; the controller only holds
    // in decode until that register is free.
    assign i_req.ready = w_in_ready;
    assign w_accept    = i_req.valid && w_in_ready;
    assign w_req       = i_req.payload;

    scsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (w_accept),
        .i_status   (w_status),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    // Decode finds the class for the request size by comparison against the
    // capacities, and the class and slot of an address by comparison against
    // the region bounds and a shift by the slot size. Allocation reads the
    // link word at the head in decode and moves the head in the next cycle;
    // a moving resize pushes the old slot in that same cycle, since the two
    // slots always lie in different classes.
    scsa_datapath #(
        .POOL_BYTES (POOL_BYTES)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_req       (w_req),
        .i_out_ready (o_rsp.ready),
        .o_status    (w_status),
        .o_out_valid (w_out_valid),
        .o_out       (w_rsp)
    );

    assign o_rsp.valid   = w_out_valid;
    assign o_rsp.payload = w_rsp;
endmodule

>>> src/scsa_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module scsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;
endmodule

>>> src/scsa_ctrl.sv
// Controller state machine of the slot allocator: clearing sweep, decode,
// pop completion. Depends on scsa_pkg for the state, command and status types.
module scsa_ctrl
    import scsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  t_dp_status i_status,
    output logic       o_in_ready,
    output t_ctrl_cmd  o_cmd
);
    t_state r_state, n_state;
    logic   r_move, n_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_move  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_move  <= n_move;
        end
    end

    always_comb begin
        n_state          = r_state;
        n_move           = r_move;
        o_in_ready       = 1'b0;
        o_cmd            = '0;
        o_cmd.out_kind   = OUT_ZERO;
        o_cmd.out_status = ST_OK;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clear_done) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.clear_step = 1'b1;
                end
            end
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.load_in = i_accept;
                if (i_accept) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_status.out_free) begin
                    n_state        = S_IDLE;
                    o_cmd.load_out = 1'b1;
                    unique case (i_status.opcode)
                        OP_ALLOC: begin
                            if (i_status.too_large) begin
                                o_cmd.out_status = ST_TOO_LARGE;
                            end else if (!i_status.head_ok) begin
                                o_cmd.out_status = ST_EXHAUSTED;
                            end else begin
                                o_cmd.load_out = 1'b0;
                                o_cmd.pop_read = 1'b1;
                                n_move         = 1'b0;
                                n_state        = S_POP;
                            end
                        end
                        OP_FREE: begin
                            if (!i_status.addr_ok) begin
                                o_cmd.out_status = ST_OUTSIDE;
                            end else begin
                                o_cmd.push     = 1'b1;
                                o_cmd.out_kind = OUT_FREE;
                            end
                        end
                        OP_RESIZE: begin
                            if (!i_status.addr_ok) begin
                                o_cmd.out_status = ST_OUTSIDE;
                            end else if (i_status.fits) begin
                                o_cmd.out_kind = OUT_KEEP;
                            end else if (i_status.too_large) begin
                                o_cmd.out_status = ST_TOO_LARGE;
                            end else if (!i_status.head_ok) begin
                                o_cmd.out_status = ST_EXHAUSTED;
                            end else begin
                                o_cmd.load_out = 1'b0;
                                o_cmd.pop_read = 1'b1;
                                n_move         = 1'b1;
                                n_state        = S_POP;
                            end
                        end
                        OP_NONE: begin
                            o_cmd.out_kind = OUT_ZERO;
                        end
                        default: begin
                            o_cmd.out_kind = OUT_ZERO;
                        end
                    endcase
                end
            end
            S_POP: begin
                // The link word of the popped slot is on the RAM output now.
                o_cmd.pop_commit = 1'b1;
                o_cmd.load_out   = 1'b1;
                o_cmd.push       = r_move;
                o_cmd.out_kind   = r_move ? OUT_MOVE : OUT_ALLOC;
                n_state          = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end
endmodule

>>> src/scsa_datapath.sv
// Datapath of the slot allocator: request register, list heads, link RAM,
// address decode and result register. Depends on scsa_pkg and scsa_ram.
module scsa_datapath
    import scsa_pkg::*;
#(
    parameter int unsigned POOL_BYTES = SCSA_POOL_BYTES
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    input  t_req       i_req,
    input  logic       i_out_ready,
    output t_dp_status o_status,
    output logic       o_out_valid,
    output t_rsp       o_out
);
    localparam int unsigned REGION = POOL_BYTES / 4;
    localparam int unsigned CNT0   = REGION / 64;
    localparam int unsigned CNT1   = REGION / 256;
    localparam int unsigned CNT2   = REGION / 512;
    localparam int unsigned CNT3   = REGION / 1024;
    localparam int unsigned BASE1  = CNT0;
    localparam int unsigned BASE2  = BASE1 + CNT1;
    localparam int unsigned BASE3  = BASE2 + CNT2;
    localparam int unsigned TOTAL  = BASE3 + CNT3;
    localparam int LINK_W = $clog2(TOTAL);
    localparam int CW     = $clog2(TOTAL + 1);

    localparam int unsigned BASE_T [CLASS_CNT] = '{0, BASE1, BASE2, BASE3};
    localparam int unsigned CNT_T  [CLASS_CNT] = '{CNT0, CNT1, CNT2, CNT3};
    localparam int unsigned REG_T  [CLASS_CNT] = '{0, REGION, 2 * REGION, 3 * REGION};

    t_req               r_req;
    logic [LINK_W-1:0]  r_head    [CLASS_CNT];
    logic               r_head_ok [CLASS_CNT];
    logic [CW-1:0]      r_clr;
    logic               r_out_valid;
    t_rsp               r_out, n_out;

    logic [CLASS_W-1:0] nc, oc;
    logic               too_large, in_region, in_slot;
    logic [31:0]        a32, offset, local32, g32, start32, na32;
    logic [LINK_W-1:0]  g_old;
    logic [CW-1:0]      clr_next;
    logic               clr_end;
    logic               ram_we;
    logic [LINK_W-1:0]  ram_addr;
    logic [LINK_W:0]    ram_wdata, ram_rdata;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_req <= i_req;
        end
    end

    // Request decode from the registered request.
    always_comb begin
        too_large = r_req.request_size > SIZE_W'(MAX_CAP);
        if (r_req.request_size <= SIZE_W'(64)) begin
            nc = 2'd0;
        end else if (r_req.request_size <= SIZE_W'(256)) begin
            nc = 2'd1;
        end else if (r_req.request_size <= SIZE_W'(512)) begin
            nc = 2'd2;
        end else begin
            nc = 2'd3;
        end

        a32       = 32'(r_req.slot_address);
        in_region = 1'b1;
        if (a32 < 32'(REGION)) begin
            oc = 2'd0;
        end else if (a32 < 32'(2 * REGION)) begin
            oc = 2'd1;
        end else if (a32 < 32'(3 * REGION)) begin
            oc = 2'd2;
        end else begin
            oc        = 2'd3;
            in_region = a32 < 32'(4 * REGION);
        end
        offset  = a32 - 32'(REG_T[oc]);
        local32 = offset >> cap_shift(oc);
        in_slot = local32 < 32'(CNT_T[oc]);
        g32     = 32'(BASE_T[oc]) + local32;
        g_old   = g32[LINK_W-1:0];
        start32 = 32'(REG_T[oc]) + (local32 << cap_shift(oc));
        na32    = 32'(REG_T[nc])
                + (32'(r_head[nc] - LINK_W'(BASE_T[nc])) << cap_shift(nc));
    end

    assign o_status.clear_done = r_clr == CW'(TOTAL);
    assign o_status.out_free   = !r_out_valid || i_out_ready;
    assign o_status.opcode     = t_opcode'(r_req.opcode);
    assign o_status.too_large  = too_large;
    assign o_status.head_ok    = r_head_ok[nc];
    assign o_status.addr_ok    = in_region && in_slot;
    assign o_status.fits       = r_req.request_size <= SIZE_W'(cap_bytes(oc));

    // Power-up sweep writes the initial chain of every class.
    assign clr_next = r_clr + CW'(1);
    assign clr_end  = clr_next == CW'(BASE1) || clr_next == CW'(BASE2) ||
                      clr_next == CW'(BASE3) || clr_next == CW'(TOTAL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr <= '0;
        end else if (i_cmd.clear_step) begin
            r_clr <= clr_next;
        end
    end

    always_comb begin
        ram_we    = i_cmd.clear_step || i_cmd.push;
        ram_addr  = g_old;
        ram_wdata = {r_head_ok[oc], r_head[oc]};
        if (i_cmd.clear_step) begin
            ram_addr  = r_clr[LINK_W-1:0];
            ram_wdata = {!clr_end, clr_end ? LINK_W'(0) : clr_next[LINK_W-1:0]};
        end else if (i_cmd.pop_read) begin
            ram_addr = r_head[nc];
        end
    end

    scsa_ram #(
        .WIDTH (LINK_W + 1),
        .DEPTH (TOTAL)
    ) u_links (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // Pop and push never touch the same class in one cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < CLASS_CNT; c++) begin
                r_head[c]    <= LINK_W'(BASE_T[c]);
                r_head_ok[c] <= 1'b1;
            end
        end else begin
            for (int c = 0; c < CLASS_CNT; c++) begin
                if (i_cmd.pop_commit && nc == CLASS_W'(c)) begin
                    r_head[c]    <= ram_rdata[LINK_W-1:0];
                    r_head_ok[c] <= ram_rdata[LINK_W];
                end
                if (i_cmd.push && oc == CLASS_W'(c)) begin
                    r_head[c]    <= g_old;
                    r_head_ok[c] <= 1'b1;
                end
            end
        end
    end

    always_comb begin
        n_out        = '0;
        n_out.status = i_cmd.out_status;
        unique case (i_cmd.out_kind)
            OUT_ZERO: begin
                n_out.size_class = '0;
            end
            OUT_FREE: begin
                n_out.size_class = oc;
            end
            OUT_KEEP: begin
                n_out.result_address = start32[ADDR_W-1:0];
                n_out.size_class     = oc;
            end
            OUT_ALLOC: begin
                n_out.result_address = na32[ADDR_W-1:0];
                n_out.size_class     = nc;
            end
            OUT_MOVE: begin
                n_out.result_address = na32[ADDR_W-1:0];
                n_out.size_class     = nc;
                n_out.copy_length    = cap_bytes(oc);
                n_out.moved          = 1'b1;
            end
            default: begin
                n_out.size_class = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
endmodule

>>> test/tb_size_class_slot_allocator_unit.sv
// Self-checking testbench for size_class_slot_allocator_unit: directed and random
// allocate, free and resize traffic, checked against an in-bench free-list model.
// Depends on scsa_pkg, scsa_stream_if and the allocator RTL under src.
module tb_size_class_slot_allocator_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import scsa_pkg::*;

    // Pool geometry at the default pool size. Every region divides evenly into
    // slots, and a 20-bit address never reaches past the pool, so the
    // address-outside-pool status cannot be provoked through the ports here.
    localparam int unsigned REGION_BYTES = SCSA_POOL_BYTES / 4;
    localparam int unsigned CLASS_BYTES [4] = '{64, 256, 512, 1024};
    localparam int unsigned SLOT_TOTAL = REGION_BYTES / 64 + REGION_BYTES / 256
                                       + REGION_BYTES / 512 + REGION_BYTES / 1024;
    localparam int unsigned RANDOM_ITEMS = 500;

    // Scoreboard: a model of the four LIFO free lists plus the queue of
    // responses that are still owed by the block, oldest first.
    class slot_pool_board;
        t_rsp        owed [$];
        int unsigned errors;
        int unsigned first_slot [4];
        int unsigned slot_count [4];
        logic [12:0] heads [4];
        bit          head_ok [4];
        logic [12:0] links [SLOT_TOTAL];
        bit          link_ok [SLOT_TOTAL];

        function new();
            int unsigned g;
            int unsigned c;
            int unsigned i;
            g = 0;
            errors = 0;
            for (c = 0; c < 4; c++) begin
                first_slot[c] = g;
                slot_count[c] = REGION_BYTES / CLASS_BYTES[c];
                heads[c] = 13'(g);
                head_ok[c] = slot_count[c] > 0;
                // Fresh lists run in address order; the last slot ends the chain.
                for (i = 0; i < slot_count[c]; i++) begin
                    link_ok[g + i] = (i + 1 < slot_count[c]);
                    links[g + i] = link_ok[g + i] ? 13'(g + i + 1) : 13'd0;
                end
                g += slot_count[c];
            end
        endfunction

        // Smallest class whose slot holds the request; 4 means none does.
        function int unsigned fit_class(int unsigned bytes);
            int unsigned c;
            for (c = 0; c < 4; c++) begin
                if (bytes <= CLASS_BYTES[c]) begin
                    return c;
                end
            end
            return 4;
        endfunction

        // Maps a byte address to its class and slot index within the class.
        function bit find_slot(int unsigned addr, output int unsigned cls,
                               output int unsigned idx);
            cls = 0;
            idx = 0;
            if (addr >= SCSA_POOL_BYTES) begin
                return 1'b0;
            end
            cls = addr / REGION_BYTES;
            if (cls > 3) begin
                return 1'b0;
            end
            idx = (addr - cls * REGION_BYTES) / CLASS_BYTES[cls];
            return idx < slot_count[cls];
        endfunction

        function bit take_slot(int unsigned cls, output int unsigned addr);
            int unsigned g;
            addr = 0;
            if (!head_ok[cls]) begin
                return 1'b0;
            end
            g = heads[cls];
            heads[cls] = links[g];
            head_ok[cls] = link_ok[g];
            addr = cls * REGION_BYTES + (g - first_slot[cls]) * CLASS_BYTES[cls];
            return 1'b1;
        endfunction

        function void give_slot(int unsigned cls, int unsigned idx);
            int unsigned g;
            g = first_slot[cls] + idx;
            links[g] = heads[cls];
            link_ok[g] = head_ok[cls];
            heads[cls] = 13'(g);
            head_ok[cls] = 1'b1;
        endfunction

        // Applies one accepted request to the model and queues its response.
        function t_rsp note_request(t_req r);
            t_rsp        rsp;
            int unsigned want;
            int unsigned cls;
            int unsigned idx;
            int unsigned grant;
            rsp = '0;
            rsp.status = ST_OK;
            case (r.opcode)
                OP_ALLOC: begin
                    want = fit_class(r.request_size);
                    if (want > 3) begin
                        rsp.status = ST_TOO_LARGE;
                    end else if (!take_slot(want, grant)) begin
                        rsp.status = ST_EXHAUSTED;
                    end else begin
                        rsp.result_address = ADDR_W'(grant);
                        rsp.size_class = CLASS_W'(want);
                    end
                end
                OP_FREE: begin
                    if (!find_slot(r.slot_address, cls, idx)) begin
                        rsp.status = ST_OUTSIDE;
                    end else begin
                        give_slot(cls, idx);
                        rsp.size_class = CLASS_W'(cls);
                    end
                end
                OP_RESIZE: begin
                    if (!find_slot(r.slot_address, cls, idx)) begin
                        rsp.status = ST_OUTSIDE;
                    end else if (r.request_size <= CLASS_BYTES[cls]) begin
                        rsp.result_address = ADDR_W'(cls * REGION_BYTES
                                                     + idx * CLASS_BYTES[cls]);
                        rsp.size_class = CLASS_W'(cls);
                    end else begin
                        want = fit_class(r.request_size);
                        if (want > 3) begin
                            rsp.status = ST_TOO_LARGE;
                        end else if (!take_slot(want, grant)) begin
                            rsp.status = ST_EXHAUSTED;
                        end else begin
                            // Pop first, then return the old slot to its list.
                            give_slot(cls, idx);
                            rsp.result_address = ADDR_W'(grant);
                            rsp.size_class = CLASS_W'(want);
                            rsp.copy_length = COPY_W'(CLASS_BYTES[cls]);
                            rsp.moved = 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
            owed.push_back(rsp);
            return rsp;
        endfunction

        function void compare(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0d, got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (owed.size() == 0) begin
                $error("response with no request outstanding: address %h status %0d",
                       got.result_address, got.status);
                errors++;
                return;
            end
            want = owed.pop_front();
            compare("result_address", want.result_address, got.result_address);
            compare("status", want.status, got.status);
            compare("size_class", want.size_class, got.size_class);
            compare("copy_length", want.copy_length, got.copy_length);
            compare("moved", want.moved, got.moved);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    scsa_stream_if #(.T(t_req)) req_if ();
    scsa_stream_if #(.T(t_rsp)) rsp_if ();

    size_class_slot_allocator_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    slot_pool_board board;

    // Slots the bench believes are handed out; frees and resizes draw from here
    // so that most of the random traffic is well formed.
    logic [ADDR_W-1:0] live_slots [$];
    int unsigned       dry_hits;
    // While set, neither side inserts idle cycles.
    bit                calm;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop. The slowest legal run is well under a tenth of this: the
    // clearing pass plus under a thousand requests, stretched by the random
    // idles on both sides.
    initial begin
        #5ms;
        $display("FAILURE");
        $finish;
    end

    // Response side: ready toggles at random on the falling edge.
    initial begin
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            rsp_if.ready <= calm || ($urandom_range(99) >= 32);
        end
    end

    // Every response transfer is checked at the rising edge it happens on.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            board.check_result(rsp_if.payload);
        end
    end

    // Presents one request and holds it until the block takes it. Entered and
    // left on a falling edge; valid stays high on exit so that back-to-back
    // requests need no dead cycle.
    task automatic send_req(input logic [1:0] op, input logic [SIZE_W-1:0] bytes,
                            input logic [ADDR_W-1:0] addr);
        t_req r;
        t_rsp due;
        r.opcode = op;
        r.request_size = bytes;
        r.slot_address = addr;
        while (!calm && $urandom_range(99) < 32) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.payload <= r;
        @(posedge i_clk);
        while (!req_if.ready) begin
            @(posedge i_clk);
        end
        due = board.note_request(r);
        // Keep the list of handed-out slots in step with the model. A failed
        // resize leaves the caller holding the old slot.
        if (op == OP_ALLOC && due.status == ST_OK) begin
            live_slots.push_back(due.result_address);
        end
        if (op == OP_RESIZE) begin
            live_slots.push_back(due.status == ST_OK ? due.result_address : addr);
        end
        if (due.status == ST_EXHAUSTED) begin
            dry_hits++;
        end
        @(negedge i_clk);
    endtask

    // Holds the request side idle until every owed response has arrived.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        do begin
            @(negedge i_clk);
        end while (board.owed.size() != 0);
    endtask

    function automatic logic [SIZE_W-1:0] size_for(int unsigned cls);
        int unsigned lo;
        lo = (cls == 0) ? 0 : CLASS_BYTES[cls - 1] + 1;
        return SIZE_W'($urandom_range(CLASS_BYTES[cls], lo));
    endfunction

    // A live slot, removed from the list, with a random offset inside it.
    function automatic logic [ADDR_W-1:0] pick_live();
        int unsigned       idx;
        logic [ADDR_W-1:0] a;
        idx = $urandom_range(live_slots.size() - 1);
        a = live_slots[idx];
        live_slots.delete(idx);
        return a + ADDR_W'($urandom_range(CLASS_BYTES[a[ADDR_W-1 -: 2]] - 1));
    endfunction

    initial begin
        int unsigned n;
        int unsigned pick;
        logic [SIZE_W-1:0] bytes;
        i_rst_n = 1'b0;
        req_if.valid = 1'b0;
        req_if.payload = '0;
        calm = 1'b0;
        dry_hits = 0;
        board = new();
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. The block runs its clearing pass first; send_req
        // simply waits for ready to rise.
        // Class boundaries: a size equal to a capacity lands in that class.
        send_req(OP_ALLOC, 16'd0, '0);
        send_req(OP_ALLOC, 16'd64, '0);
        send_req(OP_ALLOC, 16'd65, '0);
        send_req(OP_ALLOC, 16'd256, '0);
        send_req(OP_ALLOC, 16'd257, '0);
        send_req(OP_ALLOC, 16'd512, '0);
        send_req(OP_ALLOC, 16'd513, '0);
        send_req(OP_ALLOC, 16'd1024, '0);
        // Oversized requests.
        send_req(OP_ALLOC, 16'd1025, '0);
        send_req(OP_ALLOC, 16'hFFFF, '0);
        // Resize that fits, given an unaligned address inside the first
        // class-1 slot: the slot start comes back and nothing moves.
        send_req(OP_RESIZE, 16'd200, 20'h40005);
        // Resize that outgrows a 64-byte slot and moves to class 3.
        send_req(OP_RESIZE, 16'd700, 20'h00040);
        // Resize failure: too large, the old slot stays put.
        send_req(OP_RESIZE, 16'd2000, 20'h00000);
        send_req(OP_RESIZE, 16'hFFFF, 20'hFFFFF);
        // Unaligned free, then a double free of the same slot; the next two
        // allocations of that class both get it.
        send_req(OP_FREE, 16'd0, 20'h801FF);
        send_req(OP_FREE, 16'hFFFF, 20'h80000);
        send_req(OP_ALLOC, 16'd300, '0);
        send_req(OP_ALLOC, 16'd300, '0);
        // Unused opcode with every input bit set: an all-zero response.
        send_req(OP_NONE, 16'hFFFF, 20'hFFFFF);
        // Free of the very last slot of the pool and of the very first.
        send_req(OP_FREE, 16'd0, 20'hFFFFF);
        send_req(OP_FREE, 16'd0, 20'h00000);
        // Resizes that fit at the top and bottom of their range.
        send_req(OP_RESIZE, 16'd1024, 20'hC0000);
        send_req(OP_RESIZE, 16'd0, 20'h40000);
        wait_drained();

        // Random part, first leg: the 1024-byte class holds only 256 slots,
        // so a run of large allocations drives it dry several times over.
        n = 0;
        while (n < 300 && dry_hits < 4) begin
            send_req(OP_ALLOC, size_for(3), '0);
            n++;
        end
        wait_drained();

        // Second leg: a mix dominated by well-formed traffic on live slots.
        while (n < RANDOM_ITEMS) begin
            // A stretch with no idling on either side.
            calm = (n >= 320 && n < 400);
            if (n == 420) begin
                wait_drained();
            end
            pick = $urandom_range(99);
            bytes = size_for($urandom_range(3));
            if ($urandom_range(9) == 0) begin
                bytes = SIZE_W'($urandom);
            end
            if (pick < 35 || live_slots.size() == 0) begin
                send_req(OP_ALLOC, bytes, ADDR_W'($urandom));
            end else if (pick < 60) begin
                send_req(OP_FREE, bytes, pick_live());
            end else if (pick < 85) begin
                send_req(OP_RESIZE, bytes, pick_live());
            end else if (pick < 95) begin
                // Noise: any opcode, any size, any address.
                send_req(2'($urandom_range(3)), SIZE_W'($urandom), ADDR_W'($urandom));
            end else begin
                // Free or resize of an arbitrary, most likely free, slot.
                send_req($urandom_range(1) ? OP_FREE : OP_RESIZE, bytes,
                         ADDR_W'($urandom));
            end
            n++;
        end
        calm = 1'b0;

        // Drain: each request finishes after its decode, or its decode and pop, so a short tail suffices.
        req_if.valid <= 1'b0;
        for (n = 0; n < 5000 && board.owed.size() != 0; n++) begin
            @(posedge i_clk);
        end
        repeat (10) @(posedge i_clk);
        if (board.owed.size() != 0) begin
            $error("%0d responses never arrived", board.owed.size());
            board.errors++;
        end
        if (board.errors == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
